### design/srs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the sensor request sequencer: link bytes,
// configuration register indexes, beat structures and the frame CRC table.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Link bytes.
  localparam logic [7:0] BYTE_START = 8'hAA;
  localparam logic [7:0] BYTE_SYNC  = 8'hA5;
  localparam logic [7:0] BYTE_POLL  = 8'h55;

  // CRC-8 of the request frame.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Request frame: start byte, command, four zero bytes, check byte.
  localparam int unsigned FRAME_LEN = 7;
  localparam int unsigned FRAME_CMD_POS = 1;
  localparam int unsigned FRAME_CRC_POS = 6;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTEMPT_LIMIT   = 2'd0,
    CFG_SYNC_POLL_LIMIT = 2'd1,
    CFG_SKIP_POLL_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] attempt_limit;
    logic [7:0] sync_poll_limit;
    logic [7:0] skip_poll_limit;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic       action;
    logic [1:0] sensor;
    logic [7:0] command;
    logic [7:0] rx_byte;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        exchange_req;
    logic        release_before;
    logic        delay_after;
    logic [2:0]  select;
    logic        done_res;
    logic        failed;
    logic [31:0] data_word;
    logic [7:0]  received_check;
  } res_t;

  typedef logic [255:0][7:0] crc_tab_t;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Frame check byte for every command value; the rest of the frame is fixed.
  function automatic crc_tab_t frame_crc_table();
    crc_tab_t   tab;
    logic [7:0] c;
    for (int n = 0; n < 256; n++) begin
      c = crc8_byte(CRC_INIT, BYTE_START);
      c = crc8_byte(c, n[7:0]);
      for (int z = 0; z < 4; z++) begin
        c = crc8_byte(c, 8'h00);
      end
      tab[n] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t FRAME_CRC = frame_crc_table();

endpackage

### design/srs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_core
// Exchange sequencer state and the single-pass decision logic that turns one
// registered input beat into one result beat.
// ----------------------------------------------------------------------------
module srs_core #(
  parameter int unsigned PAYLOAD_BYTES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  srs_pkg::item_t item,
  input  srs_pkg::cfg_t  cfg,
  output srs_pkg::res_t  res
);
  import srs_pkg::*;

  localparam int unsigned BC_LOG = $clog2(PAYLOAD_BYTES + 2);
  localparam int unsigned BC_W   = (BC_LOG > 3) ? BC_LOG : 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEND,
    PH_SYNC,
    PH_SKIP,
    PH_DATA
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [BC_W-1:0]                bc_r, bc_nxt;
  logic [7:0]                     att_r, att_nxt;
  logic [7:0]                     sync_r, sync_nxt;
  logic [7:0]                     skip_r, skip_nxt;
  logic                           last_sync_r, last_sync_nxt;
  logic [7:0]                     crc_r, crc_nxt;
  logic [7:0]                     cmd_r, cmd_nxt;
  logic [1:0]                     sensor_r, sensor_nxt;
  logic [PAYLOAD_BYTES-1:0][7:0]  pay_r, pay_nxt;
  logic [31:0]                    word;

  logic       take_hunt, take_skip, take_begin, rel;
  logic [2:0] sel;
  logic [BC_W-1:0] bc_inc;

  // Payload word: first byte in the low bits, unused bytes zero.
  for (genvar g = 0; g < 4; g++) begin : g_word
    if (g < PAYLOAD_BYTES) begin : g_byte
      assign word[8*g +: 8] = pay_r[g];
    end else begin : g_zero
      assign word[8*g +: 8] = 8'h00;
    end
  end

  assign bc_inc = bc_r + BC_W'(1);

  // Decision logic for one beat.
  always_comb begin
    phase_nxt     = phase_r;
    bc_nxt        = bc_r;
    att_nxt       = att_r;
    sync_nxt      = sync_r;
    skip_nxt      = skip_r;
    last_sync_nxt = last_sync_r;
    crc_nxt       = crc_r;
    cmd_nxt       = cmd_r;
    sensor_nxt    = sensor_r;
    pay_nxt       = pay_r;
    res           = '0;
    take_hunt     = 1'b0;
    take_skip     = 1'b0;
    take_begin    = 1'b0;
    rel           = 1'b0;

    if (!item.action) begin
      // Start: latch the request and reload every budget.
      sensor_nxt    = item.sensor;
      cmd_nxt       = item.command;
      crc_nxt       = FRAME_CRC[item.command];
      att_nxt       = cfg.attempt_limit;
      sync_nxt      = cfg.sync_poll_limit;
      skip_nxt      = cfg.skip_poll_limit;
      last_sync_nxt = 1'b0;
      take_begin    = 1'b1;
    end else begin
      unique case (phase_r)
        PH_SEND: begin
          if (32'(bc_inc) < FRAME_LEN) begin
            bc_nxt           = bc_inc;
            res.exchange_req = 1'b1;
            if (32'(bc_inc) == FRAME_CMD_POS) begin
              res.tx_byte = cmd_r;
            end else if (32'(bc_inc) == FRAME_CRC_POS) begin
              res.tx_byte = crc_r;
            end else begin
              res.tx_byte = 8'h00;
            end
          end else begin
            take_hunt = 1'b1;
          end
        end
        PH_SYNC: begin
          last_sync_nxt = (item.rx_byte == BYTE_SYNC);
          if (item.rx_byte == BYTE_SYNC) begin
            take_skip = 1'b1;
          end else begin
            take_hunt = 1'b1;
          end
        end
        PH_SKIP: begin
          last_sync_nxt = (item.rx_byte == BYTE_SYNC);
          if (skip_r != 8'd0) begin
            res.exchange_req = 1'b1;
            res.tx_byte      = BYTE_POLL;
            if (item.rx_byte == BYTE_SYNC || item.rx_byte == BYTE_POLL) begin
              skip_nxt = skip_r - 8'd1;
            end else begin
              // First other byte is dropped; the payload follows.
              bc_nxt    = '0;
              phase_nxt = PH_DATA;
            end
          end else begin
            skip_nxt   = cfg.skip_poll_limit;
            take_begin = 1'b1;
            rel        = 1'b1;
          end
        end
        PH_DATA: begin
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (bc_r == BC_W'(i)) begin
              pay_nxt[i] = item.rx_byte;
            end
          end
          bc_nxt = bc_inc;
          if (bc_r == BC_W'(PAYLOAD_BYTES)) begin
            phase_nxt          = PH_IDLE;
            res.done_res       = 1'b1;
            res.data_word      = word;
            res.received_check = item.rx_byte;
          end else begin
            res.exchange_req = 1'b1;
            res.tx_byte      = BYTE_POLL;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // Sync hunt: poll with a wait, or fall through to skip or a retry.
    if (take_hunt) begin
      if (sync_r != 8'd0) begin
        sync_nxt         = sync_r - 8'd1;
        phase_nxt        = PH_SYNC;
        res.exchange_req = 1'b1;
        res.tx_byte      = BYTE_POLL;
        res.delay_after  = 1'b1;
      end else if (last_sync_nxt) begin
        take_skip = 1'b1;
      end else begin
        sync_nxt   = cfg.sync_poll_limit;
        take_begin = 1'b1;
        rel        = 1'b1;
      end
    end

    // Entry into the filler skip.
    if (take_skip) begin
      if (skip_r != 8'd0) begin
        skip_nxt         = skip_r - 8'd1;
        phase_nxt        = PH_SKIP;
        res.exchange_req = 1'b1;
        res.tx_byte      = BYTE_POLL;
      end else begin
        skip_nxt   = cfg.skip_poll_limit;
        take_begin = 1'b1;
        rel        = 1'b1;
      end
    end

    // New attempt, or failure once the attempt budget is spent.
    if (take_begin) begin
      if (att_nxt == 8'd0) begin
        phase_nxt  = PH_IDLE;
        res.failed = 1'b1;
      end else begin
        att_nxt            = att_nxt - 8'd1;
        phase_nxt          = PH_SEND;
        bc_nxt             = '0;
        res.exchange_req   = 1'b1;
        res.tx_byte        = BYTE_START;
        res.release_before = rel;
      end
    end

    // Chip select follows every exchange request.
    sel = {1'b0, sensor_nxt} + 3'd1;
    if (res.exchange_req) begin
      res.select = sel;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bc_r        <= '0;
      att_r       <= 8'd0;
      sync_r      <= 8'd0;
      skip_r      <= 8'd0;
      last_sync_r <= 1'b0;
      crc_r       <= 8'd0;
      cmd_r       <= 8'd0;
      sensor_r    <= 2'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      att_r       <= att_nxt;
      sync_r      <= sync_nxt;
      skip_r      <= skip_nxt;
      last_sync_r <= last_sync_nxt;
      crc_r       <= crc_nxt;
      cmd_r       <= cmd_nxt;
      sensor_r    <= sensor_nxt;
    end
  end

  // Payload bytes need no reset: each is written before it is read.
  always_ff @(posedge clk) begin
    if (step) begin
      pay_r <= pay_nxt;
    end
  end

endmodule

### design/sensor_request_sync_sequencer.sv
`timescale 1ns / 1ps
// The result beat is registered: an accepted input beat waits in the input
// register until the result register can take it, which out_ready can stall.
// Throughput: one beat per cycle while out_ready allows; input register, one
// pass of decision logic, result register, so one more beat can still be
// taken while a result waits. Reset (synchronous, rst_n low): sequencer idle,
// budgets zero, both beat registers empty, limits back to 3, 10 and 10.
// ----------------------------------------------------------------------------
// sensor_request_sync_sequencer
// Byte-exchange sequencer for a request/response sensor link: sends the
// request frame, hunts the sync byte, skips filler and collects the payload.
// ----------------------------------------------------------------------------
module sensor_request_sync_sequencer #(
  parameter int unsigned PAYLOAD_BYTES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  // Input beats.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [1:0]                     in_sensor,
  input  logic [7:0]                     in_command,
  input  logic [7:0]                     in_rx_byte,
  // Result beats.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_exchange_req,
  output logic                           out_release_before,
  output logic                           out_delay_after,
  output logic [2:0]                     out_select,
  output logic                           out_done_res,
  output logic                           out_failed,
  output logic [31:0]                    out_data_word,
  output logic [7:0]                     out_received_check
);
  import srs_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  logic  in_valid_r;
  res_t  res_nxt, res_r;
  logic  out_valid_r;
  logic  step;

  // The input register advances when the result register can take a beat.
  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_limit   <= 8'd3;
      cfg_r.sync_poll_limit <= 8'd10;
      cfg_r.skip_poll_limit <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTEMPT_LIMIT:   cfg_r.attempt_limit   <= cfg_data;
        CFG_SYNC_POLL_LIMIT: cfg_r.sync_poll_limit <= cfg_data;
        CFG_SKIP_POLL_LIMIT: cfg_r.skip_poll_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{action: in_action, sensor: in_sensor, command: in_command,
                  rx_byte: in_rx_byte};
    end
  end

  srs_core #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res_nxt)
  );

  // Result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_byte        = res_r.tx_byte;
  assign out_exchange_req   = res_r.exchange_req;
  assign out_release_before = res_r.release_before;
  assign out_delay_after    = res_r.delay_after;
  assign out_select         = res_r.select;
  assign out_done_res       = res_r.done_res;
  assign out_failed         = res_r.failed;
  assign out_data_word      = res_r.data_word;
  assign out_received_check = res_r.received_check;

  // A result never reports success and failure together.
  a_done_xor_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.done_res && res_r.failed))
    else $error("result reports both done and failed");

  // Chip select is driven exactly when an exchange is requested.
  a_select_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.select != 3'd0) == res_r.exchange_req))
    else $error("chip select disagrees with exchange request");

  // Only sync polls carry the wait, and they always send the poll byte.
  a_delay_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.delay_after) |->
      (res_r.exchange_req && res_r.tx_byte == BYTE_POLL))
    else $error("wait flagged on a beat that is not a sync poll");

  // An empty result register never blocks the input side.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with result register empty");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result changed");

endmodule
